// ===== design/plt_pkg.sv =====
// plt_pkg: shared types, codes and sizes for the positional list table
// no dependencies
package plt_pkg;

    localparam int CAPACITY = 64;
    localparam int AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW       = $clog2(CAPACITY + 1);
    localparam int PW       = 7;
    localparam int XW       = (CW > PW) ? CW : PW;

    localparam logic [1:0] K_INSERT = 2'd0;
    localparam logic [1:0] K_DELETE = 2'd1;
    localparam logic [1:0] K_READ   = 2'd2;
    localparam logic [1:0] K_LOCATE = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_MISS  = 2'd3;

    typedef struct packed {
        logic [1:0]         kind;
        logic [PW-1:0]      position;
        logic signed [31:0] value;
    } t_plt_in;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] data_out;
        logic [PW-1:0]      found_position;
        logic [PW-1:0]      list_count;
        logic               is_empty;
    } t_plt_out;

    typedef struct packed {
        logic          we;
        logic [AW-1:0] waddr;
        logic [31:0]   wdata;
        logic          re;
        logic [AW-1:0] raddr;
    } t_mem_req;

endpackage

// ===== design/plt_ram.sv =====
// plt_ram: generic one-write one-read memory with registered read data
// no dependencies
module plt_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/plt_ctrl.sv =====
// plt_ctrl: command sequencer, range checks, entry count and result register
// depends on plt_pkg; drives the entry memory through a t_mem_req
module plt_ctrl
    import plt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_plt_in     i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_plt_out    o_out_item,
    output t_mem_req    o_mem_req,
    input  logic [31:0] i_mem_rdata
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_INS_RD  = 4'd1;
    localparam logic [3:0] S_INS_WR  = 4'd2;
    localparam logic [3:0] S_INS_PUT = 4'd3;
    localparam logic [3:0] S_DEL_CAP = 4'd4;
    localparam logic [3:0] S_DEL_SRD = 4'd5;
    localparam logic [3:0] S_DEL_SWR = 4'd6;
    localparam logic [3:0] S_RD_CAP  = 4'd7;
    localparam logic [3:0] S_LOC_RD  = 4'd8;
    localparam logic [3:0] S_LOC_CMP = 4'd9;
    localparam logic [3:0] S_EMIT    = 4'd10;

    logic [3:0]    r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_j, n_j;
    logic [XW-1:0] r_pos, n_pos;
    logic [31:0]   r_val, n_val;
    logic [1:0]    r_status, n_status;
    logic [31:0]   r_data, n_data;
    logic [PW-1:0] r_found, n_found;
    logic          r_out_valid, n_out_valid;
    t_plt_out      r_out, n_out;

    logic          accept;
    logic [XW-1:0] in_pos_x;
    logic [XW-1:0] cnt_x;
    logic [XW-1:0] j_x;
    logic          pos_bad_rd;
    logic          pos_bad_ins;

    assign accept      = (r_state == S_IDLE) && i_in_valid;
    assign in_pos_x    = XW'(i_in_item.position);
    assign cnt_x       = XW'(r_count);
    assign j_x         = XW'(r_j);
    assign pos_bad_rd  = (in_pos_x == '0) || (in_pos_x > cnt_x);
    assign pos_bad_ins = (in_pos_x == '0) || (in_pos_x > cnt_x + 1'b1);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_j         = r_j;
        n_pos       = r_pos;
        n_val       = r_val;
        n_status    = r_status;
        n_data      = r_data;
        n_found     = r_found;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        o_mem_req   = '0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_pos    = in_pos_x;
                    n_val    = i_in_item.value;
                    n_status = ST_OK;
                    n_data   = '0;
                    n_found  = '0;
                    n_j      = '0;
                    n_state  = S_EMIT;
                    unique case (i_in_item.kind) inside
                        K_INSERT: begin
                            if (pos_bad_ins) begin
                                n_status = ST_RANGE;
                            end else if (cnt_x == XW'(CAPACITY)) begin
                                n_status = ST_FULL;
                            end else begin
                                n_j = r_count;
                                n_state = (cnt_x >= in_pos_x) ? S_INS_RD : S_INS_PUT;
                            end
                        end
                        K_DELETE, K_READ: begin
                            if (pos_bad_rd) begin
                                n_status = ST_RANGE;
                            end else begin
                                o_mem_req.re    = 1'b1;
                                o_mem_req.raddr = AW'(in_pos_x - 1'b1);
                                n_state = (i_in_item.kind == K_DELETE) ? S_DEL_CAP : S_RD_CAP;
                            end
                        end
                        K_LOCATE: begin
                            if (r_count == '0) begin
                                n_status = ST_MISS;
                            end else begin
                                n_state = S_LOC_RD;
                            end
                        end
                        default: n_state = S_EMIT;
                    endcase
                end
            end
            // shift up: entry j takes entry j-1, walking down to the insert point
            S_INS_RD: begin
                o_mem_req.re    = 1'b1;
                o_mem_req.raddr = AW'(j_x - 1'b1);
                n_state         = S_INS_WR;
            end
            S_INS_WR: begin
                o_mem_req.we    = 1'b1;
                o_mem_req.waddr = AW'(r_j);
                o_mem_req.wdata = i_mem_rdata;
                n_j             = r_j - 1'b1;
                n_state         = ((j_x - 1'b1) >= r_pos) ? S_INS_RD : S_INS_PUT;
            end
            S_INS_PUT: begin
                o_mem_req.we    = 1'b1;
                o_mem_req.waddr = AW'(r_pos - 1'b1);
                o_mem_req.wdata = r_val;
                n_count         = r_count + 1'b1;
                n_state         = S_EMIT;
            end
            S_DEL_CAP: begin
                n_data = i_mem_rdata;
                n_j    = CW'(r_pos);
                if (r_pos < cnt_x) begin
                    n_state = S_DEL_SRD;
                end else begin
                    n_count = r_count - 1'b1;
                    n_state = S_EMIT;
                end
            end
            // shift down: entry j-1 takes entry j, walking up to the end
            S_DEL_SRD: begin
                o_mem_req.re    = 1'b1;
                o_mem_req.raddr = AW'(r_j);
                n_state         = S_DEL_SWR;
            end
            S_DEL_SWR: begin
                o_mem_req.we    = 1'b1;
                o_mem_req.waddr = AW'(j_x - 1'b1);
                o_mem_req.wdata = i_mem_rdata;
                n_j             = r_j + 1'b1;
                if ((j_x + 1'b1) < cnt_x) begin
                    n_state = S_DEL_SRD;
                end else begin
                    n_count = r_count - 1'b1;
                    n_state = S_EMIT;
                end
            end
            S_RD_CAP: begin
                n_data  = i_mem_rdata;
                n_state = S_EMIT;
            end
            S_LOC_RD: begin
                o_mem_req.re    = 1'b1;
                o_mem_req.raddr = AW'(r_j);
                n_state         = S_LOC_CMP;
            end
            S_LOC_CMP: begin
                if (i_mem_rdata == r_val) begin
                    n_found = PW'(j_x + 1'b1);
                    n_state = S_EMIT;
                end else if ((j_x + 1'b1) < cnt_x) begin
                    n_j     = r_j + 1'b1;
                    n_state = S_LOC_RD;
                end else begin
                    n_status = ST_MISS;
                    n_state  = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out.status         = r_status;
                    n_out.data_out       = r_data;
                    n_out.found_position = r_found;
                    n_out.list_count     = PW'(r_count);
                    n_out.is_empty       = (r_count == '0);
                    n_out_valid          = 1'b1;
                    n_state              = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_j      <= n_j;
        r_pos    <= n_pos;
        r_val    <= n_val;
        r_status <= n_status;
        r_data   <= n_data;
        r_found  <= n_found;
        r_out    <= n_out;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

// ===== design/positional_list_table_top.sv =====
// positional_list_table_top: ordered list of signed 32-bit entries, 1-based positions
// depends on plt_pkg, plt_ctrl and plt_ram
//
//  channel   dir   handshake                  payload
//  -------   ---   ------------------------   ----------------------------------
//  in        in    i_in_valid / o_in_ready    t_plt_in  (kind, position, value)
//  out       out   o_out_valid / i_out_ready  t_plt_out (status, data_out,
//                                             found_position, list_count, is_empty)
//
// one item at a time through one memory port pair: every entry moved costs a read
// and a write, so insert and delete time grows with the number of entries shifted,
// locate time with the match position or the count; rejects skip the memory, and
// every result is loaded into the result register
// reset (synchronous, active low) empties the list; memory contents are not cleared
// a result waiting on out does not block the next item, which only stalls at its end
module positional_list_table_top
    import plt_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_plt_in  i_in_item,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_plt_out o_out_item
);

    // request from the sequencer to the entry store
    t_mem_req    mem_req;
    logic [31:0] mem_rdata;

    // sequencer: checks, shift loops, linear search, result register
    plt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .o_mem_req   (mem_req),
        .i_mem_rdata (mem_rdata)
    );

    // entry store, read data registered
    plt_ram #(
        .DEPTH  (CAPACITY),
        .WIDTH  (32),
        .ADDR_W (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_req.we),
        .i_waddr (mem_req.waddr),
        .i_wdata (mem_req.wdata),
        .i_re    (mem_req.re),
        .i_raddr (mem_req.raddr),
        .o_rdata (mem_rdata)
    );

endmodule
